// ===== design/dstwr_pkg.sv =====
// ----------------------------------------------------------------------------
// dstwr_pkg: shared types and constants for double-sided ranging
// Holds the field widths, request and response structs, motion codes and
// the per-cell token that travels through the divider chain.
// ----------------------------------------------------------------------------
package dstwr_pkg;

   localparam int STAMP_BITS  = 32;
   localparam int FLIGHT_BITS = 40;
   localparam int LIMIT_BITS  = 16;
   localparam int PROD_BITS   = 2 * STAMP_BITS;
   localparam int DEN_BITS    = STAMP_BITS + 2;
   localparam int CELLS       = PROD_BITS;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_NEAR = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAR  = 1'b1;

   localparam logic [1:0] MOTION_FORWARD = 2'd0;
   localparam logic [1:0] MOTION_BACK    = 2'd1;
   localparam logic [1:0] MOTION_STOP    = 2'd2;

   typedef struct packed {
      logic [31:0] initiator_poll_sent;
      logic [31:0] initiator_reply_heard;
      logic [31:0] initiator_final_sent;
      logic [31:0] local_poll_heard;
      logic [31:0] local_reply_sent;
      logic [31:0] local_final_heard;
   } req_type;

   typedef struct packed {
      logic signed [FLIGHT_BITS-1:0] flight_time;
      logic [1:0]                    motion;
      logic                          zero_divisor;
   } rsp_type;

   // token handed from one divider cell to the next
   typedef struct packed {
      logic                  vld;
      logic [PROD_BITS-1:0]  num;   // remaining dividend bits, then quotient
      logic [DEN_BITS-1:0]   rem;
      logic [DEN_BITS-1:0]   den;
      logic                  neg;
      logic                  zero;
   } tok_type;

endpackage

// ===== design/ds_twr_tof_and_motion_decision.sv =====
// ----------------------------------------------------------------------------
// ds_twr_tof_and_motion_decision: ranging flight time and motion command
// Pipeline: 2 front stages, 64 division cells, 1 output register.
// Throughput: one request per cycle unless stalled; the divider chain holds one per cell.
// The chain stalls as a whole when the output register is full and unread.
// Reset: synchronous; clears valid bits, limits return to 213 and 255.
// ----------------------------------------------------------------------------
module ds_twr_tof_and_motion_decision (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dstwr_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dstwr_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic [dstwr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [dstwr_pkg::LIMIT_BITS-1:0]   csr_data
);
   import dstwr_pkg::*;

   logic [LIMIT_BITS-1:0] near_ff, far_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   tok_type               chain [0:CELLS];
   logic                  adv;

   // advance whenever the output slot is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // hold the two limits
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= LIMIT_BITS'(213);
         far_ff  <= LIMIT_BITS'(255);
      end else if (csr_write) begin
         case (csr_index)
            CSR_NEAR: near_ff <= csr_data;
            CSR_FAR:  far_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   dstwr_front u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(req_valid), .in_req(req_data), .out_tok(chain[0])
   );

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      dstwr_cell u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .in_tok(chain[g]), .out_tok(chain[g+1])
      );
   end

   dstwr_back u_back (
      .in_tok(chain[CELLS]), .near_limit(near_ff), .far_limit(far_ff), .rsp(rsp_in)
   );

   // register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= chain[CELLS].vld;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== design/dstwr_front.sv =====
// ----------------------------------------------------------------------------
// dstwr_front: intervals and products
// Two registered stages: wrap-safe differences, then the two products,
// their signed difference magnitude and the divisor.
// ----------------------------------------------------------------------------
module dstwr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_vld,
   input  dstwr_pkg::req_type in_req,
   output dstwr_pkg::tok_type out_tok
);
   import dstwr_pkg::*;

   logic                  s1_vld_ff;
   logic [STAMP_BITS-1:0] ra_ff, rb_ff, da_ff, db_ff;
   logic [PROD_BITS-1:0]  pos, negp;

   // form the four intervals modulo the stamp width
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
      end
      if (adv) begin
         ra_ff <= in_req.initiator_reply_heard[STAMP_BITS-1:0]
                - in_req.initiator_poll_sent[STAMP_BITS-1:0];
         rb_ff <= in_req.local_final_heard[STAMP_BITS-1:0]
                - in_req.local_reply_sent[STAMP_BITS-1:0];
         da_ff <= in_req.initiator_final_sent[STAMP_BITS-1:0]
                - in_req.initiator_reply_heard[STAMP_BITS-1:0];
         db_ff <= in_req.local_reply_sent[STAMP_BITS-1:0]
                - in_req.local_poll_heard[STAMP_BITS-1:0];
      end
   end

   assign pos  = PROD_BITS'(ra_ff) * PROD_BITS'(rb_ff);
   assign negp = PROD_BITS'(da_ff) * PROD_BITS'(db_ff);

   // register the product difference, its sign and the divisor as a token for the divider chain
   always_ff @(posedge clock) begin
      if (reset) begin
         out_tok.vld <= 1'b0;
      end else if (adv) begin
         out_tok.vld <= s1_vld_ff;
      end
      if (adv) begin
         out_tok.neg  <= pos < negp;
         out_tok.num  <= (pos < negp) ? negp - pos : pos - negp;
         out_tok.rem  <= '0;
         out_tok.den  <= DEN_BITS'(ra_ff) + DEN_BITS'(rb_ff)
                       + DEN_BITS'(da_ff) + DEN_BITS'(db_ff);
         out_tok.zero <= (DEN_BITS'(ra_ff) + DEN_BITS'(rb_ff)
                       + DEN_BITS'(da_ff) + DEN_BITS'(db_ff)) == '0;
      end
   end
endmodule

// ===== design/dstwr_cell.sv =====
// ----------------------------------------------------------------------------
// dstwr_cell: one restoring division step
// Shifts one dividend bit into the remainder, subtracts the divisor when
// it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module dstwr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  dstwr_pkg::tok_type in_tok,
   output dstwr_pkg::tok_type out_tok
);
   import dstwr_pkg::*;

   logic [DEN_BITS:0]   trial;
   logic                fits;
   tok_type             nxt;

   always_comb begin
      trial = {in_tok.rem, in_tok.num[PROD_BITS-1]};
      fits  = trial >= {1'b0, in_tok.den};
      nxt   = in_tok;
      nxt.rem = fits ? DEN_BITS'(trial - {1'b0, in_tok.den}) : DEN_BITS'(trial);
      nxt.num = {in_tok.num[PROD_BITS-2:0], fits};
   end

   // advance the token one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         out_tok.vld <= 1'b0;
      end else if (adv) begin
         out_tok.vld <= in_tok.vld;
      end
      if (adv) begin
         out_tok.num  <= nxt.num;
         out_tok.rem  <= nxt.rem;
         out_tok.den  <= nxt.den;
         out_tok.neg  <= nxt.neg;
         out_tok.zero <= nxt.zero;
      end
   end
endmodule

// ===== design/dstwr_back.sv =====
// ----------------------------------------------------------------------------
// dstwr_back: saturation and motion decision
// Saturates the quotient, applies the sign and picks the motion command; a zero divisor gives zero and stop.
// ----------------------------------------------------------------------------
module dstwr_back (
   input  dstwr_pkg::tok_type          in_tok,
   input  logic [dstwr_pkg::LIMIT_BITS-1:0] near_limit,
   input  logic [dstwr_pkg::LIMIT_BITS-1:0] far_limit,
   output dstwr_pkg::rsp_type          rsp
);
   import dstwr_pkg::*;

   localparam logic [PROD_BITS-1:0] POS_MAX = PROD_BITS'((65'd1 << (FLIGHT_BITS-1)) - 65'd1);
   localparam logic [PROD_BITS-1:0] NEG_MAG = PROD_BITS'(65'd1 << (FLIGHT_BITS-1));

   logic [PROD_BITS-1:0] m;
   logic                 neg;

   always_comb begin
      if (in_tok.neg) begin
         m = (in_tok.num > NEG_MAG) ? NEG_MAG : in_tok.num;
      end else begin
         m = (in_tok.num > POS_MAX) ? POS_MAX : in_tok.num;
      end
      neg = in_tok.neg && (m != '0);
      rsp.zero_divisor = in_tok.zero;
      if (in_tok.zero) begin
         rsp.flight_time = '0;
         rsp.motion      = MOTION_STOP;
      end else begin
         rsp.flight_time = neg ? -$signed(m[FLIGHT_BITS-1:0]) : $signed(m[FLIGHT_BITS-1:0]);
         if (!neg && m > PROD_BITS'(far_limit)) begin
            rsp.motion = MOTION_FORWARD;
         end else if (neg || m <= PROD_BITS'(near_limit)) begin
            rsp.motion = MOTION_BACK;
         end else begin
            rsp.motion = MOTION_STOP;
         end
      end
   end
endmodule

// ===== dv/ds_twr_tof_and_motion_decision_tb.sv =====
// ----------------------------------------------------------------------------
// ds_twr_tof_and_motion_decision_tb: ranging flight time regression
// Drives ranging timestamp requests through the block under random
// back-pressure on both channels and checks every response field against
// an integer model of the flight time and the motion command, or a directed expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ds_twr_tof_and_motion_decision_tb;
   import dstwr_pkg::*;

   localparam int DRAIN_CYCLES  = 80;
   localparam int WATCHDOG_MAX  = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 210;

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type rs;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [LIMIT_BITS-1:0]   csr_data = '0;

   rsp_type flight_q[$];
   logic [15:0] near_lim = 16'd213;
   logic [15:0] far_lim  = 16'd255;
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_go = 1'b0;
   int hold_cnt = 0;
   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   int zero_seen = 0;
   int stall_cycles = 0;
   row_type rows[$];

   ds_twr_tof_and_motion_decision i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // compute flight time and motion for one exchange
   function automatic rsp_type tof_predict(req_type r);
      logic [31:0] ra, rb, da, db;
      logic [33:0] den;
      logic [63:0] pos, negp, mag, q, m;
      bit neg;
      rsp_type o;
      ra = r.initiator_reply_heard - r.initiator_poll_sent;
      rb = r.local_final_heard - r.local_reply_sent;
      da = r.initiator_final_sent - r.initiator_reply_heard;
      db = r.local_reply_sent - r.local_poll_heard;
      den = 34'(ra) + 34'(rb) + 34'(da) + 34'(db);
      o = '0;
      if (den == 0) begin
         o.motion = MOTION_STOP;
         o.zero_divisor = 1'b1;
         return o;
      end
      pos  = 64'(ra) * 64'(rb);
      negp = 64'(da) * 64'(db);
      neg  = pos < negp;
      mag  = neg ? negp - pos : pos - negp;
      q    = mag / 64'(den);
      if (neg) begin
         m = (q > 64'h80_0000_0000) ? 64'h80_0000_0000 : q;
         if (m == 0) neg = 1'b0;
      end else begin
         m = (q > 64'h7F_FFFF_FFFF) ? 64'h7F_FFFF_FFFF : q;
      end
      o.flight_time = neg ? FLIGHT_BITS'(-m) : FLIGHT_BITS'(m);
      if (!neg && m > 64'(far_lim)) o.motion = MOTION_FORWARD;
      else if (neg || m <= 64'(near_lim)) o.motion = MOTION_BACK;
      else o.motion = MOTION_STOP;
      return o;
   endfunction

   // build one exchange from two bases and the four intervals
   function automatic req_type exchange(logic [31:0] ib, logic [31:0] lb, logic [31:0] ra,
                                        logic [31:0] da, logic [31:0] db, logic [31:0] rb);
      req_type r;
      r.initiator_poll_sent   = ib;
      r.initiator_reply_heard = ib + ra;
      r.initiator_final_sent  = ib + ra + da;
      r.local_poll_heard      = lb;
      r.local_reply_sent      = lb + db;
      r.local_final_heard     = lb + db + rb;
      return r;
   endfunction

   // random request: mostly plausible exchanges, some noise and dead ones
   function automatic req_type random_exchange();
      logic [31:0] da, db, tof, lim;
      int sel;
      req_type r;
      sel = $urandom_range(99);
      if (sel < 15) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (sel < 20) begin
         r = exchange($urandom, $urandom, 0, 0, 0, 0);
      end else if (sel < 25) begin
         r = exchange($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
         lim = (sel < 60) ? 32'hFFF : 32'hFF_FFFF;
         da  = $urandom & lim;
         db  = $urandom & lim;
         tof = (sel < 90) ? $urandom_range(600) : $urandom_range(70000);
         r = exchange($urandom, $urandom, db + 2 * tof + $urandom_range(8) - 4, da, db,
                      da + 2 * tof + $urandom_range(8) - 4);
      end
      return r;
   endfunction

   // offer one request and log its expectation on acceptance
   task automatic send_request(req_type r, bit typed, rsp_type rs);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      flight_q.push_back(typed ? rs : tof_predict(r));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (flight_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limits(logic [15:0] near_v, logic [15:0] far_v);
      csr_write = 1'b1;
      csr_index = CSR_NEAR;
      csr_data  = near_v;
      @(negedge clock);
      csr_index = CSR_FAR;
      csr_data  = far_v;
      @(negedge clock);
      csr_write = 1'b0;
      near_lim  = near_v;
      far_lim   = far_v;
   endtask

   // receiver ready, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_go && hold_cnt == 0) begin
         hold_cnt = HOLD_CYCLES;
         hold_go  = 1'b0;
      end
      if (hold_cnt > 0) begin
         rsp_ready = 1'b0;
         hold_cnt--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle);
      end
   end

   // check responses and watch for a stuck block
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flight_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            e = flight_q.pop_front();
            checked++;
            if (rsp_data.zero_divisor) zero_seen++;
            if (rsp_data.flight_time !== e.flight_time || rsp_data.motion !== e.motion ||
                rsp_data.zero_divisor !== e.zero_divisor) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: flight exp %0d got %0d, motion exp %0d got %0d,",
                            " zero exp %0b got %0b"},
                           e.flight_time, rsp_data.flight_time, e.motion, rsp_data.motion,
                           e.zero_divisor, rsp_data.zero_divisor);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (flight_q.size() == 0 && !req_valid)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_MAX) begin
         $display("watchdog expired with %0d responses outstanding", flight_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_type zr, fw, bk;
      logic [15:0] nv, fv;
      zr = '0; zr.motion = MOTION_STOP; zr.zero_divisor = 1'b1;
      fw = '0; fw.flight_time = 500; fw.motion = MOTION_FORWARD;
      bk = '0; bk.flight_time = -500; bk.motion = MOTION_BACK;
      // directed rows under the reset limits
      rows.push_back('{'0, 1'b1, zr});
      rows.push_back('{'1, 1'b1, zr});
      rows.push_back('{exchange(32'hFFFF_FFF0, 32'h5, 0, 0, 0, 0), 1'b1, zr});
      rows.push_back('{exchange(0, 0, 1000, 0, 0, 1000), 1'b1, fw});
      rows.push_back('{exchange(32'hFFFF_FF00, 32'hFFFF_FFFF, 1000, 0, 0, 1000), 1'b1, fw});
      rows.push_back('{exchange(0, 0, 0, 1000, 1000, 0), 1'b1, bk});
      rows.push_back('{exchange(0, 0, 426, 0, 0, 426), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 428, 0, 0, 428), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 510, 0, 0, 510), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 512, 0, 0, 512), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 1, 0, 0, 1), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1'b0, zr});
      rows.push_back('{exchange(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, zr});
      rows.push_back('{exchange(0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 1'b0, zr});
      rows.push_back('{{6{32'h5555_5555}}, 1'b1, zr});
      rows.push_back('{'{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF},
                       1'b0, zr});

      repeat (10) @(negedge clock);
      reset = 1'b0;
      write_limits(16'd213, 16'd255);

      // walk the directed table
      foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].rs);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin nv = 16'd213; fv = 16'd255; end
            1: begin nv = 16'd0; fv = 16'd0; end
            2: begin nv = 16'hFFFF; fv = 16'hFFFF; end
            3: begin nv = 16'd300; fv = 16'd100; end
            4: begin nv = 16'd0; fv = 16'hFFFF; end
            default: begin nv = 16'($urandom_range(600)); fv = 16'($urandom_range(600)); end
         endcase
         write_limits(nv, fv);
         send_idle = (p % 3 == 0) ? 20 : (p % 3 == 1) ? 66 : 0;
         recv_idle = (p % 3 == 0) ? 66 : (p % 3 == 1) ? 20 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // fill the chain behind a stalled receiver
            if (p == 2 && n == 20) hold_go = 1'b1;
            // let the block run empty mid-stream
            if (p == 0 && n == PHASE_ITEMS / 2) begin
               req_valid = 1'b0;
               while (flight_q.size() != 0) @(negedge clock);
            end
            send_request(random_exchange(), 1'b0, zr);
         end
         drain();
      end

      $display("sent %0d ranging requests, checked %0d responses (%0d with zero divisor)",
               sent, checked, zero_seen);
      $display("covered %0d limit settings under three back-pressure mixes", PHASES + 1);
      if (mismatches == 0 && flight_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, flight_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dstwr_pkg.sv
design/dstwr_front.sv
design/dstwr_cell.sv
design/dstwr_back.sv
design/ds_twr_tof_and_motion_decision.sv
dv/ds_twr_tof_and_motion_decision_tb.sv
